[rtl/core/kt_pkg.sv]
// kt_pkg: shared types and fixed field widths for the keyed table unit.
// No dependencies. Imported by the interfaces, the cell, the controller and the top level.
package kt_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned QTY_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_FIND    = 3'd0,
    OP_ADD     = 3'd1,
    OP_REPLACE = 3'd2,
    OP_DELETE  = 3'd3,
    OP_CLEAR   = 3'd4
  } kt_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } kt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } kt_state_e;

  // Control part of the scan token that walks down the cell chain.
  typedef struct packed {
    logic valid;
    logic found;
  } kt_tok_t;

endpackage

[rtl/core/kt_req_if.sv]
// kt_req_if: request channel (valid/ready plus request payload).
// Depends on kt_pkg for the field widths.
interface kt_req_if;
  import kt_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [NAME_W-1:0]   key_name;
  logic [NAME_W-1:0]   new_name;
  logic [QTY_W-1:0]    new_quantity;

  modport source (output valid, opcode, key_name, new_name, new_quantity, input ready);
  modport sink   (input valid, opcode, key_name, new_name, new_quantity, output ready);

endinterface

[rtl/core/kt_rsp_if.sv]
// kt_rsp_if: response channel (valid/ready plus result payload).
// Depends on kt_pkg for the field widths.
interface kt_rsp_if;
  import kt_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  found_index;
  logic [NAME_W-1:0]   entry_name;
  logic [QTY_W-1:0]    entry_quantity;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_index, entry_name, entry_quantity, entry_count,
                  input ready);
  modport sink   (input valid, status, found_index, entry_name, entry_quantity, entry_count,
                  output ready);

endinterface

[rtl/core/kt_cell.sv]
// kt_cell: one table slot of the chain, holding a name and a quantity.
// Depends on kt_pkg. The scan token enters from the left neighbor and leaves registered.
module kt_cell #(
  parameter int unsigned NAME_BITS     = 64,
  parameter int unsigned QUANTITY_BITS = 16,
  parameter int unsigned IDX_W         = 6,
  parameter int unsigned CNT_W         = 7,
  parameter int unsigned CELL_IDX      = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  kt_pkg::kt_op_e           op_i,
  input  logic [NAME_BITS-1:0]     key_i,
  input  logic [NAME_BITS-1:0]     new_name_i,
  input  logic [QUANTITY_BITS-1:0] new_qty_i,
  input  logic [CNT_W-1:0]         count_i,
  input  kt_pkg::kt_tok_t          tok_i,
  input  logic [IDX_W-1:0]         tok_idx_i,
  input  logic [QUANTITY_BITS-1:0] tok_qty_i,
  input  logic [NAME_BITS-1:0]     nxt_name_i,
  input  logic [QUANTITY_BITS-1:0] nxt_qty_i,
  output logic [NAME_BITS-1:0]     name_o,
  output logic [QUANTITY_BITS-1:0] qty_o,
  output kt_pkg::kt_tok_t          tok_o,
  output logic [IDX_W-1:0]         tok_idx_o,
  output logic [QUANTITY_BITS-1:0] tok_qty_o
);
  import kt_pkg::*;

  logic [NAME_BITS-1:0]     name_q, name_d;
  logic [QUANTITY_BITS-1:0] qty_q, qty_d;
  kt_tok_t                  tok_q, tok_d;
  logic [IDX_W-1:0]         tok_idx_q, tok_idx_d;
  logic [QUANTITY_BITS-1:0] tok_qty_q, tok_qty_d;
  logic                     held;
  logic                     keyed_op;
  logic                     hit;
  logic                     at_tail;

  assign held     = CNT_W'(CELL_IDX) < count_i;
  assign at_tail  = CNT_W'(CELL_IDX) == count_i;
  assign keyed_op = (op_i == OP_FIND) || (op_i == OP_REPLACE) || (op_i == OP_DELETE);
  // First match only: an earlier hit is carried in the token.
  assign hit      = tok_i.valid && !tok_i.found && keyed_op && held && (name_q == key_i);

  always_comb begin
    name_d = name_q;
    qty_d  = qty_q;
    if (tok_i.valid) begin
      priority if (op_i == OP_ADD && at_tail) begin
        name_d = new_name_i;
        qty_d  = new_qty_i;
      end else if (op_i == OP_REPLACE && hit) begin
        name_d = new_name_i;
        qty_d  = new_qty_i;
      end else if (op_i == OP_DELETE && (hit || tok_i.found)) begin
        // Right neighbor is not yet touched by this token, so its old value moves down.
        name_d = nxt_name_i;
        qty_d  = nxt_qty_i;
      end
    end
  end

  always_comb begin
    tok_d.valid = tok_i.valid;
    tok_d.found = tok_i.found | hit;
    tok_idx_d   = hit ? IDX_W'(CELL_IDX) : tok_idx_i;
    tok_qty_d   = hit ? qty_q : tok_qty_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_q    <= name_d;
    qty_q     <= qty_d;
    tok_idx_q <= tok_idx_d;
    tok_qty_q <= tok_qty_d;
  end

  assign name_o    = name_q;
  assign qty_o     = qty_q;
  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;
  assign tok_qty_o = tok_qty_q;

endmodule

[rtl/core/kt_ctrl.sv]
// kt_ctrl: request capture, entry count, scan launch and result register.
// Depends on kt_pkg, kt_req_if and kt_rsp_if.
module kt_ctrl #(
  parameter int unsigned MAX_ENTRIES   = 64,
  parameter int unsigned NAME_BITS     = 64,
  parameter int unsigned QUANTITY_BITS = 16,
  parameter int unsigned IDX_W         = 6,
  parameter int unsigned CNT_W         = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  kt_req_if.sink                   req_i,
  kt_rsp_if.source                 rsp_o,
  output kt_pkg::kt_op_e           op_o,
  output logic [NAME_BITS-1:0]     key_o,
  output logic [NAME_BITS-1:0]     new_name_o,
  output logic [QUANTITY_BITS-1:0] new_qty_o,
  output logic [CNT_W-1:0]         count_o,
  output kt_pkg::kt_tok_t          launch_o,
  input  kt_pkg::kt_tok_t          tail_tok_i,
  input  logic [IDX_W-1:0]         tail_idx_i,
  input  logic [QUANTITY_BITS-1:0] tail_qty_i
);
  import kt_pkg::*;

  kt_state_e                state_q, state_d;
  kt_op_e                   op_q;
  logic [NAME_BITS-1:0]     key_q, nname_q;
  logic [QUANTITY_BITS-1:0] nqty_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     launch_q;
  logic                     done_found_q;
  logic [IDX_W-1:0]         done_idx_q;
  logic [QUANTITY_BITS-1:0] done_qty_q;

  logic                     rsp_valid_q, rsp_valid_d;
  kt_status_e               status_q, status_d;
  logic [INDEX_W-1:0]       index_q, index_d;
  logic [NAME_W-1:0]        ename_q, ename_d;
  logic [QTY_W-1:0]         eqty_q, eqty_d;
  logic [COUNT_W-1:0]       ecount_q, ecount_d;

  logic                     accept;
  logic                     out_load;
  logic                     capture;

  kt_status_e               st_res;
  logic [IDX_W-1:0]         idx_res;
  logic [NAME_BITS-1:0]     name_res;
  logic [QUANTITY_BITS-1:0] qty_res;

  logic [QUANTITY_BITS+QTY_W-1:0] qty_in_ext;
  logic [IDX_W+INDEX_W-1:0]       idx_ext;
  logic [NAME_BITS+NAME_W-1:0]    name_ext;
  logic [QUANTITY_BITS+QTY_W-1:0] qty_out_ext;
  logic [CNT_W+COUNT_W-1:0]       cnt_ext;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_SCAN;
      S_SCAN:  if (tail_tok_i.valid) state_d = S_FIN;
      S_FIN:   if (!rsp_valid_q || rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req_i.ready = 1'b0;
    capture     = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE:  req_i.ready = 1'b1;
      S_SCAN:  capture = tail_tok_i.valid;
      S_FIN:   out_load = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  assign accept     = req_i.valid && req_i.ready;
  assign qty_in_ext = {{QUANTITY_BITS{1'b0}}, req_i.new_quantity};

  // Result of the finished request
  always_comb begin
    st_res   = ST_OK;
    idx_res  = '0;
    name_res = '0;
    qty_res  = '0;
    count_d  = count_q;
    unique case (op_q)
      OP_FIND: begin
        if (done_found_q) begin
          idx_res  = done_idx_q;
          name_res = key_q;  // a hit means the stored name equals the key
          qty_res  = done_qty_q;
        end else begin
          st_res = ST_NOT_FOUND;
        end
      end
      OP_ADD: begin
        if (count_q == CNT_W'(MAX_ENTRIES)) begin
          st_res = ST_FULL;
        end else begin
          idx_res = count_q[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REPLACE: begin
        if (done_found_q) begin
          idx_res = done_idx_q;
        end else begin
          st_res = ST_NOT_FOUND;
        end
      end
      OP_DELETE: begin
        if (done_found_q) begin
          idx_res = done_idx_q;
          count_d = count_q - CNT_W'(1);
        end else begin
          st_res = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign idx_ext     = {{INDEX_W{1'b0}}, idx_res};
  assign name_ext    = {{NAME_W{1'b0}}, name_res};
  assign qty_out_ext = {{QTY_W{1'b0}}, qty_res};
  assign cnt_ext     = {{COUNT_W{1'b0}}, count_d};

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    status_d    = status_q;
    index_d     = index_q;
    ename_d     = ename_q;
    eqty_d      = eqty_q;
    ecount_d    = ecount_q;
    if (out_load) begin
      rsp_valid_d = 1'b1;
      status_d    = st_res;
      index_d     = idx_ext[INDEX_W-1:0];
      ename_d     = name_ext[NAME_W-1:0];
      eqty_d      = qty_out_ext[QTY_W-1:0];
      ecount_d    = cnt_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      launch_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= accept;
      rsp_valid_q <= rsp_valid_d;
      if (out_load) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= kt_op_e'(req_i.opcode);
      key_q   <= req_i.key_name[NAME_BITS-1:0];
      nname_q <= req_i.new_name[NAME_BITS-1:0];
      nqty_q  <= qty_in_ext[QUANTITY_BITS-1:0];
    end
    if (capture) begin
      done_found_q <= tail_tok_i.found;
      done_idx_q   <= tail_idx_i;
      done_qty_q   <= tail_qty_i;
    end
    status_q <= status_d;
    index_q  <= index_d;
    ename_q  <= ename_d;
    eqty_q   <= eqty_d;
    ecount_q <= ecount_d;
  end

  assign op_o           = op_q;
  assign key_o          = key_q;
  assign new_name_o     = nname_q;
  assign new_qty_o      = nqty_q;
  assign count_o        = count_q;
  assign launch_o.valid = launch_q;
  assign launch_o.found = 1'b0;

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.found_index    = index_q;
  assign rsp_o.entry_name     = ename_q;
  assign rsp_o.entry_quantity = eqty_q;
  assign rsp_o.entry_count    = ecount_q;

endmodule

[rtl/core/keyed_table_with_compacting_delete_unit.sv]
// keyed_table_with_compacting_delete_unit: top level, controller plus a chain of table cells.
// Depends on kt_pkg, kt_req_if, kt_rsp_if, kt_cell and kt_ctrl.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    opcode, key_name, new_name, new_quantity
//   rsp_o    out  valid/ready    status, found_index, entry_name, entry_quantity, entry_count
//
// A request's result is loaded after a scan token walks the cell chain one cell per cycle:
// launch register, each cell's token register, then the controller's capture of the tail.
// The next request is taken in the cycle after the result is loaded, so the unit works on
// one request at a time; the result register may still hold an untaken result meanwhile.
// A stalled rsp_o holds the unit in its final step. Reset clears the count and the
// handshake state; cell contents stay undefined.
module keyed_table_with_compacting_delete_unit #(
  parameter int unsigned MAX_ENTRIES   = 64,
  parameter int unsigned NAME_BITS     = 64,
  parameter int unsigned QUANTITY_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  kt_req_if.sink   req_i,
  kt_rsp_if.source rsp_o
);
  import kt_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  kt_op_e                   op;
  logic [NAME_BITS-1:0]     key;
  logic [NAME_BITS-1:0]     new_name;
  logic [QUANTITY_BITS-1:0] new_qty;
  logic [CNT_W-1:0]         count;

  kt_tok_t                  tok      [MAX_ENTRIES+1];
  logic [IDX_W-1:0]         tok_idx  [MAX_ENTRIES+1];
  logic [QUANTITY_BITS-1:0] tok_qty  [MAX_ENTRIES+1];
  logic [NAME_BITS-1:0]     cell_name[MAX_ENTRIES];
  logic [QUANTITY_BITS-1:0] cell_qty [MAX_ENTRIES];
  logic [NAME_BITS-1:0]     nxt_name [MAX_ENTRIES];
  logic [QUANTITY_BITS-1:0] nxt_qty  [MAX_ENTRIES];

  kt_ctrl #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .NAME_BITS    (NAME_BITS),
    .QUANTITY_BITS(QUANTITY_BITS),
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .op_o       (op),
    .key_o      (key),
    .new_name_o (new_name),
    .new_qty_o  (new_qty),
    .count_o    (count),
    .launch_o   (tok[0]),
    .tail_tok_i (tok[MAX_ENTRIES]),
    .tail_idx_i (tok_idx[MAX_ENTRIES]),
    .tail_qty_i (tok_qty[MAX_ENTRIES])
  );

  assign tok_idx[0] = '0;
  assign tok_qty[0] = '0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    // The last cell has no right neighbor; what it copies on a delete lies past the count.
    if (g == MAX_ENTRIES - 1) begin : g_end
      assign nxt_name[g] = cell_name[g];
      assign nxt_qty[g]  = cell_qty[g];
    end else begin : g_mid
      assign nxt_name[g] = cell_name[g+1];
      assign nxt_qty[g]  = cell_qty[g+1];
    end

    kt_cell #(
      .NAME_BITS    (NAME_BITS),
      .QUANTITY_BITS(QUANTITY_BITS),
      .IDX_W        (IDX_W),
      .CNT_W        (CNT_W),
      .CELL_IDX     (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (op),
      .key_i      (key),
      .new_name_i (new_name),
      .new_qty_i  (new_qty),
      .count_i    (count),
      .tok_i      (tok[g]),
      .tok_idx_i  (tok_idx[g]),
      .tok_qty_i  (tok_qty[g]),
      .nxt_name_i (nxt_name[g]),
      .nxt_qty_i  (nxt_qty[g]),
      .name_o     (cell_name[g]),
      .qty_o      (cell_qty[g]),
      .tok_o      (tok[g+1]),
      .tok_idx_o  (tok_idx[g+1]),
      .tok_qty_o  (tok_qty[g+1])
    );
  end

endmodule

[test/keyed_table_with_compacting_delete_unit_tb.sv]
// Testbench for keyed_table_with_compacting_delete_unit: random and directed table requests.
// A cycle-free table model predicts each result; a monitor checks results in order.
// Depends on kt_pkg, kt_req_if, kt_rsp_if and the unit itself.
`timescale 1ns / 100ps

module keyed_table_with_compacting_delete_unit_tb;
  import kt_pkg::*;

  localparam int unsigned TBL_DEPTH      = 64;
  localparam int unsigned TOTAL_REQS     = 1950;
  localparam int unsigned POOL_SIZE      = 12;
  localparam int unsigned CHAIN_CYCLES   = TBL_DEPTH + 3;
  localparam int unsigned IDLE_LIMIT     = 5000;
  localparam int unsigned HOLDOFF_AT     = 300;
  localparam int unsigned HOLDOFF_CYCLES = 600;

  // Opcodes with no meaning; the unit answers them without touching the table.
  localparam logic [OPCODE_W-1:0] OP_RSVD_LO  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_MID = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_HI  = 3'd7;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} mix_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_e;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [NAME_W-1:0]   key_name;
    logic [NAME_W-1:0]   new_name;
    logic [QTY_W-1:0]    new_quantity;
    bit                  drain_first;
  } table_req_t;

  typedef struct {
    kt_status_e          status;
    logic [INDEX_W-1:0]  index;
    logic [NAME_W-1:0]   name;
    logic [QTY_W-1:0]    quantity;
    logic [COUNT_W-1:0]  count;
  } table_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kt_req_if req ();
  kt_rsp_if rsp ();

  keyed_table_with_compacting_delete_unit #(
    .MAX_ENTRIES  (TBL_DEPTH),
    .NAME_BITS    (NAME_W),
    .QUANTITY_BITS(QTY_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Table model state
  logic [NAME_W-1:0] model_names [TBL_DEPTH];
  logic [QTY_W-1:0]  model_qtys  [TBL_DEPTH];
  int unsigned       model_held = 0;

  table_req_t    pending_reqs[$];
  table_result_t expected_results[$];
  logic [NAME_W-1:0] name_pool [POOL_SIZE];

  int unsigned mismatch_count = 0;
  int unsigned req_total;
  table_req_t  next_req;
  table_result_t got_result;
  table_result_t want_result;

  int unsigned burst_left;
  int unsigned gap_left;

  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned rx_stall_left;
  int unsigned rx_taken;
  int unsigned holdoff_left;
  bit          holdoff_done;

  function automatic table_result_t apply_table_op(logic [OPCODE_W-1:0] op,
                                                   logic [NAME_W-1:0] key,
                                                   logic [NAME_W-1:0] nname,
                                                   logic [QTY_W-1:0] nqty);
    table_result_t r;
    int pos;
    r.status   = ST_OK;
    r.index    = '0;
    r.name     = '0;
    r.quantity = '0;
    pos = -1;
    // first match only, so duplicates resolve to the lowest index
    for (int i = 0; i < model_held; i++) begin
      if (pos < 0 && model_names[i] == key) pos = i;
    end
    case (op)
      OP_FIND: begin
        if (pos >= 0) begin
          r.index    = pos[INDEX_W-1:0];
          r.name     = model_names[pos];
          r.quantity = model_qtys[pos];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_ADD: begin
        if (model_held < TBL_DEPTH) begin
          model_names[model_held] = nname;
          model_qtys[model_held]  = nqty;
          r.index = model_held[INDEX_W-1:0];
          model_held++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_REPLACE: begin
        if (pos >= 0) begin
          model_names[pos] = nname;
          model_qtys[pos]  = nqty;
          r.index = pos[INDEX_W-1:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_DELETE: begin
        if (pos >= 0) begin
          for (int i = pos; i + 1 < model_held; i++) begin
            model_names[i] = model_names[i + 1];
            model_qtys[i]  = model_qtys[i + 1];
          end
          model_held--;
          r.index = pos[INDEX_W-1:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: model_held = 0;
      default: ;
    endcase
    r.count = model_held[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic push_req(logic [OPCODE_W-1:0] op, logic [NAME_W-1:0] key,
                          logic [NAME_W-1:0] nname, logic [QTY_W-1:0] nqty,
                          bit drain_first = 1'b0);
    table_req_t t;
    t.opcode       = op;
    t.key_name     = key;
    t.new_name     = nname;
    t.new_quantity = nqty;
    t.drain_first  = drain_first;
    pending_reqs.push_back(t);
    req_total++;
  endtask

  function automatic logic [NAME_W-1:0] rand_name();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [NAME_W-1:0] pick_name(int unsigned pool_pct);
    if ($urandom_range(99, 0) < pool_pct) return name_pool[$urandom_range(POOL_SIZE - 1, 0)];
    return rand_name();
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return QTY_W'($urandom_range(16'hffff, 0));
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_op(mix_e mix);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 2) return OPCODE_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    if (r < 3) return OP_CLEAR;
    case (mix)
      PH_GROW:   return (r < 60) ? OP_ADD : (r < 75) ? OP_FIND : (r < 87) ? OP_REPLACE : OP_DELETE;
      PH_SHRINK: return (r < 20) ? OP_ADD : (r < 40) ? OP_FIND : (r < 50) ? OP_REPLACE : OP_DELETE;
      default:   return (r < 35) ? OP_ADD : (r < 60) ? OP_FIND : (r < 78) ? OP_REPLACE : OP_DELETE;
    endcase
  endfunction

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid        <= 1'b0;
      req.opcode       <= '0;
      req.key_name     <= '0;
      req.new_name     <= '0;
      req.new_quantity <= '0;
      burst_left = $urandom_range(40, 1);
      gap_left   = 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_table_op(req.opcode, req.key_name,
                                                  req.new_name, req.new_quantity));
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() == 0 ||
                     (pending_reqs[0].drain_first && expected_results.size() != 0)) begin
          req.valid <= 1'b0;
        end else begin
          next_req = pending_reqs.pop_front();
          req.valid        <= 1'b1;
          req.opcode       <= next_req.opcode;
          req.key_name     <= next_req.key_name;
          req.new_name     <= next_req.new_name;
          req.new_quantity <= next_req.new_quantity;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(90, 1);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Result receiver: its own stall pattern plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rx_mode       = RX_OPEN;
      rx_mode_left  = 0;
      rx_stall_left = 0;
      rx_taken      = 0;
      holdoff_left  = 0;
      holdoff_done  = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rx_taken++;
      if (!holdoff_done && rx_taken >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(RX_BURSTY, RX_OPEN));
          rx_mode_left = $urandom_range(400, 20);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          RX_OPEN: rsp.ready <= 1'b1;
          RX_COIN: rsp.ready <= 1'($urandom_range(1, 0));
          default: begin
            if (rx_stall_left > 0) begin
              rx_stall_left--;
              rsp.ready <= 1'b0;
            end else begin
              rsp.ready <= 1'b1;
              if ($urandom_range(7, 0) == 0) rx_stall_left = $urandom_range(80, 1);
            end
          end
        endcase
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      got_result.status   = kt_status_e'(rsp.status);
      got_result.index    = rsp.found_index;
      got_result.name     = rsp.entry_name;
      got_result.quantity = rsp.entry_quantity;
      got_result.count    = rsp.entry_count;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 64'(rsp.status), 64'(0));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.status !== want_result.status)
          report_mismatch("status", 64'(got_result.status), 64'(want_result.status));
        if (got_result.index !== want_result.index)
          report_mismatch("found_index", 64'(got_result.index), 64'(want_result.index));
        if (got_result.name !== want_result.name)
          report_mismatch("entry_name", got_result.name, want_result.name);
        if (got_result.quantity !== want_result.quantity)
          report_mismatch("entry_quantity", 64'(got_result.quantity),
                          64'(want_result.quantity));
        if (got_result.count !== want_result.count)
          report_mismatch("entry_count", 64'(got_result.count), 64'(want_result.count));
      end
    end
  end

  // Watchdog: ends the run after too long without any transaction
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("keyed_table_with_compacting_delete_unit verification failed");
    $finish;
  end

  initial begin
    mix_e        mix;
    int unsigned phase_len;
    req_total        = 0;

    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) name_pool[i] = rand_name();

    // Directed: empty table, extremes, duplicates, shifting and last-entry delete
    push_req(OP_FIND,    name_pool[0], rand_name(), pick_qty());
    push_req(OP_REPLACE, name_pool[1], rand_name(), pick_qty());
    push_req(OP_DELETE,  name_pool[0], rand_name(), pick_qty());
    push_req(OP_ADD,     rand_name(),  '0,           '0);
    push_req(OP_ADD,     rand_name(),  '1,           '1);
    push_req(OP_ADD,     rand_name(),  name_pool[2], 16'h1234);
    push_req(OP_ADD,     rand_name(),  name_pool[2], 16'hbeef);
    push_req(OP_FIND,    name_pool[2], rand_name(),  pick_qty());
    push_req(OP_FIND,    '1,           rand_name(),  pick_qty());
    push_req(OP_FIND,    '0,           rand_name(),  pick_qty());
    push_req(OP_REPLACE, name_pool[2], name_pool[3], 16'h8001);
    push_req(OP_FIND,    name_pool[2], rand_name(),  pick_qty());
    push_req(OP_DELETE,  '0,           rand_name(),  pick_qty());
    push_req(OP_DELETE,  name_pool[2], rand_name(),  pick_qty());
    push_req(OP_FIND,    name_pool[3], rand_name(),  pick_qty());
    push_req(OP_RSVD_LO, name_pool[3], rand_name(),  pick_qty());
    push_req(OP_RSVD_MID, rand_name(), rand_name(),  pick_qty());
    push_req(OP_RSVD_HI, '1,           '1,           '1);
    push_req(OP_CLEAR,   rand_name(),  rand_name(),  pick_qty());
    push_req(OP_FIND,    '1,           rand_name(),  pick_qty());
    push_req(OP_ADD,     rand_name(),  name_pool[4], pick_qty());
    push_req(OP_FIND,    name_pool[4], rand_name(),  pick_qty());

    // Fill to full and two past, then find, replace and delete on the full table
    push_req(OP_CLEAR, rand_name(), rand_name(), pick_qty(), 1'b1);
    for (int i = 0; i < TBL_DEPTH + 2; i++) push_req(OP_ADD, rand_name(), pick_name(50), pick_qty());
    push_req(OP_FIND,    name_pool[5], rand_name(), pick_qty());
    push_req(OP_REPLACE, pick_name(90), pick_name(60), pick_qty());
    push_req(OP_DELETE,  pick_name(90), rand_name(), pick_qty());

    // Random phases with biased operation mix
    while (req_total < TOTAL_REQS) begin
      mix = mix_e'($urandom_range(PH_MIXED, PH_GROW));
      phase_len = $urandom_range(120, 20);
      for (int i = 0; i < phase_len && req_total < TOTAL_REQS; i++) begin
        push_req(pick_op(mix), pick_name(85), pick_name(70), pick_qty(),
                 i == 0 && $urandom_range(5, 0) == 0);
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || req.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (CHAIN_CYCLES + 10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("keyed_table_with_compacting_delete_unit verification clean");
    end else begin
      $display("keyed_table_with_compacting_delete_unit verification failed");
    end
    $finish;
  end

endmodule
